// File: design/free_running_timer_16bit_x3_defines.svh
// Assertion macros for the free-running timer block.
// Assertions compile out when ASSERT_OFF is defined.
`ifndef FREE_RUNNING_TIMER_16BIT_X3_DEFINES_SVH
`define FREE_RUNNING_TIMER_16BIT_X3_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never hold at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// File: design/frt_pkg.sv
package frt_pkg;

	localparam int NUM_CH  = 3;
	localparam int IRQ_W   = 3;
	localparam int NUM_FLAGS = 3;    // overflow, compare A, compare B
	localparam int PADDR_W = 3;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// register offsets within a channel
	localparam logic [3:0] OFF_TCR       = 4'h0;
	localparam logic [3:0] OFF_TCSR      = 4'h1;
	localparam logic [3:0] OFF_LAST_WIDE = 4'h9;

	// offset[3:1] of the 16-bit registers
	localparam logic [2:0] WIDE_FRC  = 3'd1;
	localparam logic [2:0] WIDE_OCRA = 3'd2;
	localparam logic [2:0] WIDE_OCRB = 3'd3;

	// TCR clock select
	localparam logic [1:0] RATE_DIV4  = 2'd0;
	localparam logic [1:0] RATE_DIV8  = 2'd1;
	localparam logic [1:0] RATE_DIV32 = 2'd2;
	localparam logic [1:0] RATE_EXT   = 2'd3;

	localparam logic [4:0] MASK_DIV2  = 5'd1;
	localparam logic [4:0] MASK_DIV4  = 5'd3;
	localparam logic [4:0] MASK_DIV8  = 5'd7;
	localparam logic [4:0] MASK_DIV32 = 5'd31;

	localparam int FLAG_LSB = 4;     // flags and enables start at bit 4
	localparam int CCLR_BIT = 0;     // TCSR: clear counter on compare A

	localparam logic [7:0] RD_UNMAPPED = 8'hFF;

	localparam logic [PADDR_W-1:0] CFG_ADDR_EXT_DIV4 = 3'd0;

endpackage

// File: design/free_running_timer_16bit_x3.sv
// Three 16-bit free-running timer channels with byte-wide register access.
// Requests pass through an input register, then the result register.
// Throughput: one request per cycle while out_ready holds; all channels update in parallel in a single pass.
// Reset (arst_n, async, active low): all timer state, latch, prescaler, request lines and ext_div4 clear;
// the pipeline empties; the IRQ output registers are not reset. No clearing pass is needed.
`include "free_running_timer_16bit_x3_defines.svh"

module free_running_timer_16bit_x3
	import frt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [7:0]         address,
	input  logic [7:0]         write_data,

	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         read_data,
	output logic [IRQ_W-1:0]   ovf_irq,
	output logic [IRQ_W-1:0]   cmpa_irq,
	output logic [IRQ_W-1:0]   cmpb_irq,

	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// ------------------------------------------------------------------
	// Configuration: a single bit selecting /4 (1) or /2 (0) for
	// channels in external clock mode.
	// ------------------------------------------------------------------
	logic ext_div4_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_div4_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[PADDR_W-1] == CFG_ADDR_EXT_DIV4[PADDR_W-1]) begin
				ext_div4_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == CFG_ADDR_EXT_DIV4[PADDR_W-1]) begin
			prdata[0] = ext_div4_q;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control. Stage 1 holds the request; the whole update
	// happens as it moves into the result register, so the next request
	// in stage 1 already sees the new state.
	// ------------------------------------------------------------------
	logic      v_s1;
	opcode_t   op_s1;
	logic [7:0] addr_s1;
	logic [7:0] wdata_s1;
	logic      adv;

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= opcode_t'(opcode);
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	// ------------------------------------------------------------------
	// Timer state. Requests are kept flag-major: req[0] overflow,
	// req[1] compare A, req[2] compare B, one bit per channel.
	// seen_q bit k marks flag k as read while set, which arms the
	// clear-by-writing-zero.
	// ------------------------------------------------------------------
	logic [NUM_CH-1:0][7:0]               ctrl_q,   ctrl_d;
	logic [NUM_CH-1:0][7:0]               status_q, status_d;
	logic [NUM_CH-1:0][NUM_FLAGS-1:0]     seen_q,   seen_d;
	logic [NUM_CH-1:0][15:0]              cnt_q,    cnt_d;
	logic [NUM_CH-1:0][15:0]              ocra_q,   ocra_d;
	logic [NUM_CH-1:0][15:0]              ocrb_q,   ocrb_d;
	logic [NUM_CH-1:0][15:0]              icr_q,    icr_d;
	logic [7:0]                           latch_q,  latch_d;
	logic [4:0]                           presc_q,  presc_d;
	logic [NUM_FLAGS-1:0][NUM_CH-1:0]     req_q,    req_d;
	logic [7:0]                           rdata_d;

	logic [7:0] rdata_q;
	logic [NUM_FLAGS-1:0][IRQ_W-1:0] irq_q;
	logic out_valid_q;

	always_comb begin
		logic [3:0]  off;
		logic        hit;
		logic [15:0] wv;
		logic [4:0]  mask;
		logic [16:0] nxt;
		logic        ma;
		logic        mb;
		logic [7:0]  st;

		ctrl_d   = ctrl_q;
		status_d = status_q;
		seen_d   = seen_q;
		cnt_d    = cnt_q;
		ocra_d   = ocra_q;
		ocrb_d   = ocrb_q;
		icr_d    = icr_q;
		latch_d  = latch_q;
		presc_d  = presc_q;
		req_d    = req_q;
		rdata_d  = '0;
		off      = addr_s1[3:0];
		wv       = '0;
		mask     = MASK_DIV4;
		nxt      = '0;
		ma       = 1'b0;
		mb       = 1'b0;
		st       = '0;
		hit      = 1'b0;

		unique case (op_s1)
			OP_WRITE: begin
				for (int i = 0; i < NUM_CH; i++) begin
					hit = (addr_s1[7:4] == 4'(i + 1));
					if (hit) begin
						if (off == OFF_TCR) begin
							ctrl_d[i] = wdata_s1;
						end else if (off == OFF_TCSR) begin
							// low nibble is software-owned; flags only clear after a read
							status_d[i] = {status_q[i][7:4], wdata_s1[3:0]};
							for (int k = 0; k < NUM_FLAGS; k++) begin
								if (!wdata_s1[FLAG_LSB+k] && seen_q[i][k]) begin
									status_d[i][FLAG_LSB+k] = 1'b0;
									seen_d[i][k]            = 1'b0;
									req_d[k][i]             = 1'b0;
								end
							end
						end else if (off <= OFF_LAST_WIDE) begin
							if (!off[0]) begin
								latch_d = wdata_s1;
							end else begin
								unique case (off[3:1])
									WIDE_FRC:  cnt_d[i]  = {latch_q, wdata_s1};
									WIDE_OCRA: ocra_d[i] = {latch_q, wdata_s1};
									WIDE_OCRB: ocrb_d[i] = {latch_q, wdata_s1};
									default:   icr_d[i]  = {latch_q, wdata_s1};
								endcase
							end
						end
					end
				end
			end

			OP_READ: begin
				rdata_d = RD_UNMAPPED;
				for (int i = 0; i < NUM_CH; i++) begin
					hit = (addr_s1[7:4] == 4'(i + 1));
					if (hit) begin
						if (off == OFF_TCR) begin
							rdata_d = ctrl_q[i];
						end else if (off == OFF_TCSR) begin
							seen_d[i] = seen_q[i] | status_q[i][FLAG_LSB +: NUM_FLAGS];
							rdata_d   = status_q[i];
						end else if (off <= OFF_LAST_WIDE) begin
							if (!off[0]) begin
								unique case (off[3:1])
									WIDE_FRC:  wv = cnt_q[i];
									WIDE_OCRA: wv = ocra_q[i];
									WIDE_OCRB: wv = ocrb_q[i];
									default:   wv = icr_q[i];
								endcase
								latch_d = wv[7:0];
								rdata_d = wv[15:8];
							end else begin
								rdata_d = latch_q;
							end
						end
					end
				end
			end

			OP_TICK: begin
				for (int i = 0; i < NUM_CH; i++) begin
					unique case (ctrl_q[i][1:0])
						RATE_DIV4:  mask = MASK_DIV4;
						RATE_DIV8:  mask = MASK_DIV8;
						RATE_DIV32: mask = MASK_DIV32;
						RATE_EXT:   mask = ext_div4_q ? MASK_DIV4 : MASK_DIV2;
					endcase
					if ((presc_q & mask) == '0) begin
						ma = (cnt_q[i] == ocra_q[i]);
						mb = (cnt_q[i] == ocrb_q[i]);
						if (status_q[i][CCLR_BIT] && ma) begin
							nxt = '0;
						end else begin
							nxt = {1'b0, cnt_q[i]} + 17'd1;
						end
						st = status_q[i];
						if (nxt[16]) st[FLAG_LSB]   = 1'b1;
						if (ma)      st[FLAG_LSB+1] = 1'b1;
						if (mb)      st[FLAG_LSB+2] = 1'b1;
						cnt_d[i]    = nxt[15:0];
						status_d[i] = st;
						for (int k = 0; k < NUM_FLAGS; k++) begin
							if (ctrl_q[i][FLAG_LSB+k] && st[FLAG_LSB+k]) begin
								req_d[k][i] = 1'b1;
							end
						end
					end
				end
				presc_d = presc_q + 5'd1;
			end

			OP_NOP: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			status_q <= '0;
			seen_q   <= '0;
			cnt_q    <= '0;
			ocra_q   <= '0;
			ocrb_q   <= '0;
			icr_q    <= '0;
			latch_q  <= '0;
			presc_q  <= '0;
			req_q    <= '0;
		end else if (adv) begin
			ctrl_q   <= ctrl_d;
			status_q <= status_d;
			seen_q   <= seen_d;
			cnt_q    <= cnt_d;
			ocra_q   <= ocra_d;
			ocrb_q   <= ocrb_d;
			icr_q    <= icr_d;
			latch_q  <= latch_d;
			presc_q  <= presc_d;
			req_q    <= req_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register: read byte plus the request lines after the update.
	// Only the low IRQ_W channels reach the outputs.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= rdata_d;
			for (int k = 0; k < NUM_FLAGS; k++) begin
				irq_q[k] <= IRQ_W'(req_d[k]);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = rdata_q;
	assign ovf_irq   = irq_q[0];
	assign cmpa_irq  = irq_q[1];
	assign cmpb_irq  = irq_q[2];

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	logic [NUM_FLAGS-1:0][NUM_CH-1:0] flag_v;
	logic [NUM_FLAGS-1:0][NUM_CH-1:0] seen_v;

	always_comb begin
		for (int k = 0; k < NUM_FLAGS; k++) begin
			for (int i = 0; i < NUM_CH; i++) begin
				flag_v[k][i] = status_q[i][FLAG_LSB+k];
				seen_v[k][i] = seen_q[i][k];
			end
		end
	end

	// a request line only ever rises as a tick is applied
	`ASSERT_IMPLY(a_req_rise_on_tick, |(req_q & ~$past(req_q)), $past(adv && op_s1 == OP_TICK), "request rose outside a tick")
	// the prescaler only moves on ticks
	`ASSERT_IMPLY(a_presc_on_tick, presc_q != $past(presc_q), $past(adv && op_s1 == OP_TICK), "prescaler moved outside a tick")
	// a pending request or an armed clear needs its flag still set
	`ASSERT_NEVER(a_req_without_flag, |((req_q | seen_v) & ~flag_v), "request or read mark without flag")

endmodule
